FILE: design/psu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types and constants for the PNG scanline unfilter core.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

  localparam int MAX_LINE_BYTES  = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  // column index into the row store, and the wider row length register
  localparam int COL_W  = $clog2(MAX_LINE_BYTES);
  localparam int LEN_W  = 14;
  localparam int BPP_W  = 4;
  localparam int LIDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // APB side
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef enum logic [0:0] {
    REG_BPP  = 1'b0,
    REG_LINE = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  // one word in flight between decode and reconstruction
  typedef struct packed {
    logic              err;
    logic [7:0]        x;
    filter_e           filt;
    logic [COL_W-1:0]  col;
    logic              first_row;
    logic              use_left;
    logic [LIDX_W-1:0] lidx;
    logic              last;
  } item_t;

endpackage

`default_nettype wire

FILE: design/psu_row_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_row_ram
// Previous-row store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_row_ram
  import psu_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [COL_W-1:0] wr_addr_i,
  input  wire logic [7:0]       wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [COL_W-1:0] rd_addr_i,
  output logic      [7:0]       rd_data_o
);

  logic [7:0] mem [MAX_LINE_BYTES];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/psu_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_cfg
// APB register file: bytes per pixel and row length.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_cfg
  import psu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output logic      [BPP_W-1:0]  bpp_o,
  output logic      [LEN_W-1:0]  line_o
);

  logic [BPP_W-1:0] bpp_q;
  logic [LEN_W-1:0] line_q;
  logic             wr_en;
  reg_e             reg_sel;

  assign reg_sel = reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q  <= BPP_W'(4);
      line_q <= LEN_W'(1024);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BPP:  bpp_q  <= pwdata[BPP_W-1:0];
        REG_LINE: line_q <= pwdata[LEN_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BPP:  prdata = {{(CFG_DW-BPP_W){1'b0}}, bpp_q};
      REG_LINE: prdata = {{(CFG_DW-LEN_W){1'b0}}, line_q};
      default:  prdata = '0;
    endcase
  end

  assign bpp_o  = bpp_q;
  assign line_o = line_q;

endmodule

`default_nettype wire

FILE: design/psu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_ctrl
// Input stage: row/column tracking, filter type decode, error lock-out,
// row store read issue and the stage register feeding reconstruction.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_ctrl
  import psu_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic             frame_start_i,
  input  wire logic [BPP_W-1:0] bpp_i,
  input  wire logic [LEN_W-1:0] line_i,
  input  wire logic             adv_i,
  output logic                  s1_valid_o,
  output item_t                 s1_item_o,
  output logic                  rd_en_o,
  output logic      [COL_W-1:0] rd_addr_o
);

  logic [COL_W-1:0] col_q, col_d, col_e;
  filter_e          filt_q, filt_d;
  logic             expect_q, expect_d, expect_e;
  logic             first_q, first_d, first_e;
  logic             failed_q, failed_d, failed_e;
  logic             s1_valid_q;
  item_t            s1_item_q, item_d;
  logic             acc, load;
  logic [BPP_W-1:0] bpp_eff;
  logic [LEN_W-1:0] len_eff;
  logic             last;

  assign in_ready_o = !s1_valid_q || adv_i;
  assign acc        = in_valid_i && in_ready_o;

  // clamp registers to the supported range
  always_comb begin
    bpp_eff = bpp_i;
    if (bpp_i == '0) bpp_eff = BPP_W'(1);
    else if (bpp_i > BPP_W'(MAX_PIXEL_BYTES)) bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
    len_eff = line_i;
    if (line_i == '0) len_eff = LEN_W'(1);
    else if (line_i > LEN_W'(MAX_LINE_BYTES)) len_eff = LEN_W'(MAX_LINE_BYTES);
  end

  // frame start overrides position and error state on this word
  assign failed_e = failed_q && !frame_start_i;
  assign expect_e = expect_q || frame_start_i;
  assign first_e  = first_q || frame_start_i;
  assign col_e    = frame_start_i ? '0 : col_q;
  assign last     = ({1'b0, col_e} + LEN_W'(1)) >= len_eff;

  always_comb begin
    col_d    = col_q;
    filt_d   = filt_q;
    expect_d = expect_q;
    first_d  = first_q;
    failed_d = failed_q;
    load     = 1'b0;

    item_d           = '0;
    item_d.x         = in_byte_i;
    item_d.filt      = filt_q;
    item_d.col       = col_e;
    item_d.first_row = first_e;
    item_d.use_left  = {1'b0, col_e} >= LEN_W'(bpp_eff);
    item_d.lidx      = LIDX_W'(bpp_eff - BPP_W'(1));
    item_d.last      = last;

    if (acc) begin
      col_d    = col_e;
      expect_d = expect_e;
      first_d  = first_e;
      failed_d = failed_e;
      if (!failed_e) begin
        if (expect_e) begin
          if (in_byte_i > 8'(FILT_PAETH)) begin
            failed_d   = 1'b1;
            load       = 1'b1;
            item_d.err = 1'b1;
          end else begin
            filt_d   = filter_e'(in_byte_i[2:0]);
            expect_d = 1'b0;
            col_d    = '0;
          end
        end else begin
          load = 1'b1;
          if (last) begin
            expect_d = 1'b1;
            first_d  = 1'b0;
            col_d    = '0;
          end else begin
            col_d = col_e + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      filt_q     <= FILT_NONE;
      expect_q   <= 1'b1;
      first_q    <= 1'b1;
      failed_q   <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      filt_q   <= filt_d;
      expect_q <= expect_d;
      first_q  <= first_d;
      failed_q <= failed_d;
      if (in_ready_o) begin
        s1_valid_q <= load;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_item_q <= item_d;
    end
  end

  // issue the up neighbour read with the load, so its data lands with the word in stage 1
  assign rd_en_o    = load && !item_d.err;
  assign rd_addr_o  = col_e;
  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = s1_item_q;

  a_err_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && item_d.err) |=> failed_q)
    else $error("error word did not set the lock-out");

  a_last_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !item_d.err && item_d.last) |=> (expect_q && !first_q))
    else $error("last byte of a row did not re-arm the type byte");

  a_no_load_when_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && failed_q && !frame_start_i) |-> !load)
    else $error("word passed while locked out");

endmodule

`default_nettype wire

FILE: design/psu_recon.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_recon
// Reconstruction stage: neighbour selection, filter arithmetic, row store
// write back and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_recon
  import psu_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s1_valid_i,
  input  item_t                 s1_item_i,
  input  wire logic [7:0]       rd_data_i,
  output logic                  adv_o,
  output logic                  wr_en_o,
  output logic      [COL_W-1:0] wr_addr_o,
  output logic      [7:0]       wr_data_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output logic      [7:0]       pixel_byte_o,
  output logic                  line_last_o,
  output logic                  bad_filter_o
);

  // last reconstructed bytes and last up neighbours, newest at index 0
  logic [7:0] left_q [MAX_PIXEL_BYTES];
  logic [7:0] upl_q  [MAX_PIXEL_BYTES];

  logic              out_valid_q;
  logic [7:0]        pixel_q;
  logic              last_q, bad_q;
  logic [7:0]        a, b, c, pred, r;
  logic signed [9:0] da, db, dc;
  logic [9:0]        pa, pb, pc;
  logic [8:0]        avg_sum;
  logic              shift_en;

  assign adv_o = !out_valid_q || out_ready_i;

  assign b = s1_item_i.first_row ? 8'd0 : rd_data_i;
  assign a = s1_item_i.use_left ? left_q[s1_item_i.lidx] : 8'd0;
  assign c = s1_item_i.use_left ? upl_q[s1_item_i.lidx] : 8'd0;

  // Paeth distances; ties go a, then b, then c
  assign da = $signed({2'b00, b}) - $signed({2'b00, c});
  assign db = $signed({2'b00, a}) - $signed({2'b00, c});
  assign dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
  assign pa = da[9] ? 10'(-da) : 10'(da);
  assign pb = db[9] ? 10'(-db) : 10'(db);
  assign pc = dc[9] ? 10'(-dc) : 10'(dc);

  assign avg_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (s1_item_i.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc)        pred = b;
        else                      pred = c;
      end
      default:    pred = 8'd0;
    endcase
  end

  assign r = s1_item_i.x + pred;

  assign shift_en  = s1_valid_i && adv_o && !s1_item_i.err;
  assign wr_en_o   = shift_en;
  assign wr_addr_o = s1_item_i.col;
  assign wr_data_o = r;

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
        left_q[k] <= left_q[k-1];
        upl_q[k]  <= upl_q[k-1];
      end
      left_q[0] <= r;
      upl_q[0]  <= b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && s1_valid_i) begin
      pixel_q <= s1_item_i.err ? 8'd0 : r;
      last_q  <= s1_item_i.err ? 1'b0 : s1_item_i.last;
      bad_q   <= s1_item_i.err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = pixel_q;
  assign line_last_o  = last_q;
  assign bad_filter_o = bad_q;

  a_err_word_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && bad_q) |-> (pixel_q == 8'd0 && !last_q))
    else $error("error word carries data");

endmodule

`default_nettype wire

FILE: design/png_scanline_unfilter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core
// PNG scanline filter reconstruction (None, Sub, Up, Average, Paeth) on a
// byte stream, one filter-type byte heading each row.
// ----------------------------------------------------------------------------
// Path: decode register, then result register, before a data byte's result
//   shows on the outputs. Throughput: one byte per cycle while the output
//   is not stalled; type bytes are consumed with no result.
//   The left neighbour loop closes within the reconstruction stage.
// Reset: asynchronous, active low; control clears, registers return to
//   4 bytes per pixel and 1024 bytes per row. Row store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module png_scanline_unfilter_core
  import psu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // filtered byte stream
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              frame_start_i,
  // reconstructed bytes
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [7:0]        pixel_byte_o,
  output logic                   line_last_o,
  output logic                   bad_filter_o,
  // APB configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  logic [BPP_W-1:0] bpp;
  logic [LEN_W-1:0] line_len;
  logic             adv;
  logic             s1_valid;
  item_t            s1_item;
  logic             rd_en;
  logic [COL_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic             wr_en;
  logic [COL_W-1:0] wr_addr;
  logic [7:0]       wr_data;

  // registers; the user must write them only while the stream is idle, the block does not enforce it
  psu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bpp_o   (bpp),
    .line_o  (line_len)
  );

  // Decode stage: tracks column and row, swallows type bytes, locks out
  // after a bad filter type until the next frame start, and issues the
  // row store read so the up neighbour lands with the word in stage 1.
  psu_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .frame_start_i (frame_start_i),
    .bpp_i         (bpp),
    .line_i        (line_len),
    .adv_i         (adv),
    .s1_valid_o    (s1_valid),
    .s1_item_o     (s1_item),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr)
  );

  // Previous row. A read and a write in the same cycle never hit the same
  // column: a whole row plus its type byte separate the two.
  psu_row_ram u_row_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Reconstruction: left and up-left come from short shift lines that hold
  // the last eight bytes of the current row; the column guard means they
  // never reach into the previous row, so no clear is needed at row start.
  psu_recon u_recon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid),
    .s1_item_i    (s1_item),
    .rd_data_i    (rd_data),
    .adv_o        (adv),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .pixel_byte_o (pixel_byte_o),
    .line_last_o  (line_last_o),
    .bad_filter_o (bad_filter_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/unfilter_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unfilter_check_pkg
// Scoreboard for the PNG scanline unfilter core. It mirrors the row state,
// rebuilds every byte the core should produce and checks each output word.
// ----------------------------------------------------------------------------

package unfilter_check_pkg;
  import psu_pkg::*;

  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
    logic       bad;
  } recon_word_t;

  class unfilter_scoreboard;
    logic [BPP_W-1:0] bpp_reg;
    logic [LEN_W-1:0] len_reg;
    logic [7:0]       prev_row [MAX_LINE_BYTES];
    logic [7:0]       left_hist [MAX_PIXEL_BYTES];
    logic [7:0]       up_hist [MAX_PIXEL_BYTES];
    int unsigned      col;
    int unsigned      stored_upto;   // prev_row[0 .. stored_upto-1] written
    filter_e          row_filt;
    bit               want_type;
    bit               first_row;
    bit               errored;
    recon_word_t      expected_bytes [$];
    int unsigned      fails;

    function new();
      bpp_reg     = 4;
      len_reg     = 1024;
      col         = 0;
      stored_upto = 0;
      row_filt    = FILT_NONE;
      want_type   = 1'b1;
      first_row   = 1'b1;
      errored     = 1'b0;
      fails       = 0;
      clear_hist();
    endfunction

    function void clear_hist();
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_hist[k] = 8'h00;
        up_hist[k]   = 8'h00;
      end
    endfunction

    function int unsigned eff_bpp();
      int unsigned v;
      v = bpp_reg;
      if (v == 0) v = 1;
      if (v > MAX_PIXEL_BYTES) v = MAX_PIXEL_BYTES;
      return v;
    endfunction

    function int unsigned eff_len();
      int unsigned v;
      v = len_reg;
      if (v == 0) v = 1;
      if (v > MAX_LINE_BYTES) v = MAX_LINE_BYTES;
      return v;
    endfunction

    function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int pa, pb, pc;
      pa = int'(b) - int'(c);
      pb = int'(a) - int'(c);
      pc = int'(a) + int'(b) - 2 * int'(c);
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      // ties go to a, then b
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
    endfunction

    // next data byte would read a row store entry never written
    function bit need_restart();
      return !errored && !want_type && !first_row && col >= stored_upto;
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    function void set_reg(reg_e r, logic [CFG_DW-1:0] v);
      case (r)
        REG_BPP:  bpp_reg = v[BPP_W-1:0];
        REG_LINE: len_reg = v[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CFG_DW-1:0] reg_value(reg_e r);
      return (r == REG_BPP) ? CFG_DW'(bpp_reg) : CFG_DW'(len_reg);
    endfunction

    // Accepted input word. Returns 0 when the core just drops it.
    function bit take_word(logic [7:0] x, logic fs);
      int unsigned bpp, len;
      logic [7:0]  a, b, c, r;
      bit          ends_row;
      if (fs) begin
        errored   = 1'b0;
        first_row = 1'b1;
        want_type = 1'b1;
        col       = 0;
      end
      if (errored) return 1'b0;

      if (want_type) begin
        if (x > 8'(FILT_PAETH)) begin
          errored = 1'b1;
          expected_bytes.push_back('{pixel: 8'h00, last: 1'b0, bad: 1'b1});
          return 1'b1;
        end
        row_filt  = filter_e'(x[2:0]);
        want_type = 1'b0;
        col       = 0;
        clear_hist();
        return 1'b1;
      end

      bpp = eff_bpp();
      len = eff_len();
      if (col >= MAX_LINE_BYTES) col = MAX_LINE_BYTES - 1;

      b = first_row ? 8'h00 : prev_row[col];
      a = (col >= bpp) ? left_hist[bpp-1] : 8'h00;
      c = (col >= bpp) ? up_hist[bpp-1] : 8'h00;

      case (row_filt)
        FILT_SUB:   r = x + a;
        FILT_UP:    r = x + b;
        FILT_AVG:   r = x + 8'((9'(a) + 9'(b)) >> 1);
        FILT_PAETH: r = x + paeth_pick(a, b, c);
        default:    r = x;
      endcase

      for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
        left_hist[k] = left_hist[k-1];
        up_hist[k]   = up_hist[k-1];
      end
      left_hist[0] = r;
      up_hist[0]   = b;
      prev_row[col] = r;
      if (col + 1 > stored_upto) stored_upto = col + 1;

      ends_row = (col + 1) >= len;
      if (ends_row) begin
        want_type = 1'b1;
        first_row = 1'b0;
        col       = 0;
      end else begin
        col++;
      end
      expected_bytes.push_back('{pixel: r, last: ends_row, bad: 1'b0});
      return 1'b1;
    endfunction

    task report_mismatch(string what);
      fails++;
      if (fails <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_word(logic [7:0] pixel, logic last, logic bad);
      recon_word_t w;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected word pixel=%02h last=%b bad=%b",
                                  pixel, last, bad));
        return;
      end
      w = expected_bytes.pop_front();
      if (pixel !== w.pixel)
        report_mismatch($sformatf("pixel_byte %02h, want %02h", pixel, w.pixel));
      if (last !== w.last)
        report_mismatch($sformatf("line_last %b, want %b", last, w.last));
      if (bad !== w.bad)
        report_mismatch($sformatf("bad_filter %b, want %b", bad, w.bad));
    endtask

    task check_reg(reg_e r, logic [CFG_DW-1:0] got);
      if (got !== reg_value(r))
        report_mismatch($sformatf("%s reads %h, want %h", r.name(), got, reg_value(r)));
    endtask

    task flush_leftovers();
      recon_word_t w;
      while (expected_bytes.size() != 0) begin
        w = expected_bytes.pop_front();
        report_mismatch($sformatf("missing word pixel=%02h last=%b bad=%b",
                                  w.pixel, w.last, w.bad));
      end
    endtask
  endclass

endpackage

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for png_scanline_unfilter_core: directed rows through
// every filter and the error path, then randomised frames under random
// configs, a long hold-off on the output and a long row fragment under the
// widest row length setting.
// ----------------------------------------------------------------------------

module tb;
  import psu_pkg::*;
  import unfilter_check_pkg::*;

  localparam int      HALF_PERIOD    = 2;
  localparam int      RANDOM_WORDS   = 580;
  localparam int      LONG_ROW_WORDS = 64;     // data bytes under the widest length
  localparam int      LONG_HOLD      = 300;    // output hold-off, cycles
  localparam int      SETTLE_CYCLES  = 4;      // settle margin after drain
  localparam int      END_WAIT       = 10000;
  localparam longint  CYCLE_LIMIT    = 2000000;
  localparam logic [7:0] BAD_TYPE_MIN = 8'(FILT_PAETH) + 8'd1;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid    = 1'b0;
  logic [7:0]        in_byte     = 8'h00;
  logic              frame_start = 1'b0;
  logic              out_ready   = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [CFG_AW-1:0] paddr       = '0;
  logic [CFG_DW-1:0] pwdata      = '0;

  wire               in_ready;
  wire               out_valid;
  wire [7:0]         pixel_byte;
  wire               line_last;
  wire               bad_filter;
  wire [CFG_DW-1:0]  prdata;
  wire               pready;

  unfilter_scoreboard sb = new();

  longint unsigned cycles     = 0;
  int unsigned     words_done = 0;   // words the core acted on
  int unsigned     burst_left = 0;
  bit              flat_out   = 1'b0; // sender never idles in this phase
  bit              hold_req   = 1'b0; // ask the sink for a long hold-off

  png_scanline_unfilter_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_byte_i    (in_byte),
    .frame_start_i(frame_start),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pixel_byte_o (pixel_byte),
    .line_last_o  (line_last),
    .bad_filter_o (bad_filter),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** png_scanline_unfilter_core: FAILED **");
      $finish;
    end
  end

  // Output side: every accepted word goes straight to the scoreboard.
  // Sampled in the active region, so these are the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready)
      sb.check_word(pixel_byte, line_last, bad_filter);
  end

  // Sink pacing. Runs of ready high or low of random length, mostly high, with
  // the odd long open stretch. A hold request keeps ready low for a long
  // hold-off so the core backs up and has to stall its input.
  initial begin : sink_pacing
    int unsigned run_left;
    int unsigned hold_left;
    bit          lvl;
    run_left  = 0;
    hold_left = 0;
    lvl       = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          lvl      = ($urandom_range(3) != 0);
          run_left = lvl ? $urandom_range(1, ($urandom_range(4) == 0) ? 80 : 12)
                         : $urandom_range(1, 10);
        end
        run_left--;
        out_ready <= lvl;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // APB access: setup cycle, then access until pready. Read data is taken at
  // the closing edge; the bus returns to idle after every transfer.
  // ---------------------------------------------------------------------------
  function automatic logic [CFG_AW-1:0] reg_addr(reg_e r);
    return CFG_AW'({r, 2'b00});
  endfunction

  task automatic apb_cycle(input reg_e r, input logic wr, input logic [CFG_DW-1:0] wdata,
                           output logic [CFG_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= reg_addr(r);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_back(input reg_e r);
    logic [CFG_DW-1:0] got;
    apb_cycle(r, 1'b0, '0, got);
    sb.check_reg(r, got);
  endtask

  // upper bits of the data carry junk; the register keeps only its width
  task automatic write_reg(input reg_e r, input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] unused;
    apb_cycle(r, 1'b1, value, unused);
    sb.set_reg(r, value);
    read_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Stream side
  // ---------------------------------------------------------------------------

  // Offer one word and hold it until taken. Returns at the accepting edge with
  // valid still high; the caller drives the next word or drops valid in the
  // same step.
  task automatic push_word(input logic [7:0] x, input logic fs);
    in_byte     <= x;
    frame_start <= fs;
    in_valid    <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    if (sb.take_word(x, fs)) words_done++;
  endtask

  // Burst bookkeeping: at the end of a burst, idle for a random gap unless flat out.
  task automatic feed(input logic [7:0] x, input logic fs);
    push_word(x, fs);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!flat_out) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  // Stop offering and wait until every predicted word is out, plus a margin.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic row2(input filter_e f, input logic fs, input logic [7:0] d0,
                      input logic [7:0] d1);
    feed(8'(f), fs);
    feed(d0, 1'b0);
    feed(d1, 1'b0);
  endtask

  // extremes show up often so Paeth ties and wrap-around get hit
  function automatic logic [7:0] pick_data();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    if ($urandom_range(11) == 0) return 8'($urandom_range(int'(BAD_TYPE_MIN), 255));
    return 8'($urandom_range(int'(FILT_PAETH)));
  endfunction

  // Mostly well-formed rows with random content. Noise: stray frame starts
  // mid-row (some with junk types) and dropped words after an error.
  function automatic void pick_word(output logic [7:0] x, output logic fs);
    fs = 1'b0;
    x  = pick_data();
    if (sb.errored) begin
      if ($urandom_range(3) != 0) begin
        fs = 1'b1;
        x  = pick_type();
      end
    end else if (sb.need_restart()) begin
      // row grew past anything stored: open a new frame instead
      fs = 1'b1;
      x  = pick_type();
    end else if (sb.want_type) begin
      fs = ($urandom_range(15) == 0);
      x  = pick_type();
    end else if ($urandom_range(199) == 0) begin
      fs = 1'b1;
      x  = $urandom_range(1) ? pick_type() : 8'($urandom_range(255));
    end
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(9))
      0:       return '0;
      1:       return LEN_W'($urandom_range(25, 300));
      default: return LEN_W'($urandom_range(1, 24));
    endcase
  endfunction

  // First few phases pin the register extremes, the rest are random and may
  // leave one register alone. A phase may open mid-row, so a change of
  // length can cut the row short on its next word.
  task automatic set_phase_config(input int unsigned p);
    logic [CFG_DW-1:0] bpp_val, len_val;
    bit                do_bpp, do_len;
    bpp_val = $urandom();
    len_val = $urandom();
    do_bpp  = 1'b1;
    do_len  = 1'b1;
    case (p)
      0: begin bpp_val[BPP_W-1:0] = BPP_W'(8);  len_val[LEN_W-1:0] = LEN_W'(20); end
      1: begin bpp_val[BPP_W-1:0] = BPP_W'(0);  len_val[LEN_W-1:0] = LEN_W'(0);  end
      2: begin bpp_val[BPP_W-1:0] = BPP_W'(15); len_val[LEN_W-1:0] = LEN_W'(1);  end
      3: begin bpp_val[BPP_W-1:0] = BPP_W'(1);  len_val[LEN_W-1:0] = LEN_W'(9);  end
      default: begin
        bpp_val[BPP_W-1:0] = BPP_W'($urandom_range(15));
        len_val[LEN_W-1:0] = pick_len();
        do_bpp = ($urandom_range(3) != 0);
        do_len = ($urandom_range(3) != 0);
      end
    endcase
    if (do_bpp) write_reg(REG_BPP, bpp_val);
    if (do_len) write_reg(REG_LINE, len_val);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]        x;
    logic              fs;
    logic [CFG_DW-1:0] big_len;
    int unsigned       p;
    int unsigned       n;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values first
    read_back(REG_BPP);
    read_back(REG_LINE);

    // Directed: one pixel byte wide, two bytes per row. Every filter in turn,
    // then a bad type, dropped words, a bad type with frame start, a Paeth
    // first row, and a frame start landing mid-row.
    write_reg(REG_BPP, 1);
    write_reg(REG_LINE, 2);
    row2(FILT_NONE,  1'b1, 8'h00, 8'hFF);
    row2(FILT_SUB,   1'b0, 8'h80, 8'hFF);
    row2(FILT_UP,    1'b0, 8'hFF, 8'h01);
    row2(FILT_AVG,   1'b0, 8'h7F, 8'hFF);
    row2(FILT_PAETH, 1'b0, 8'h00, 8'h00);
    feed(BAD_TYPE_MIN, 1'b0);
    feed(8'h12, 1'b0);
    feed(8'h34, 1'b0);
    feed(8'hFF, 1'b1);
    row2(FILT_PAETH, 1'b1, 8'h80, 8'h7F);
    feed(8'(FILT_SUB), 1'b1);
    feed(8'h55, 1'b0);
    row2(FILT_UP,    1'b1, 8'h01, 8'hFE);
    drain();

    // Random phases. Phase 0 runs flat out into a long output hold-off so
    // the core fills and stalls its input. Between phases the sender waits
    // for every result before touching the registers.
    words_done = 0;
    p = 0;
    while (words_done < RANDOM_WORDS) begin
      set_phase_config(p);
      flat_out = (p == 0) || ($urandom_range(3) == 0);
      n = (p == 0) ? 100 : $urandom_range(10, 80);
      if (p == 0) hold_req = 1'b1;
      repeat (n) begin
        pick_word(x, fs);
        feed(x, fs);
      end
      drain();
      p++;
    end

    // Widest length setting: register all ones, clamped to the store depth,
    // so a long Paeth row fragment must run with no early row end.
    flat_out = 1'b0;
    big_len  = $urandom();
    big_len[LEN_W-1:0] = '1;
    write_reg(REG_LINE, big_len);
    write_reg(REG_BPP, CFG_DW'($urandom_range(15)));
    feed(8'(FILT_PAETH), 1'b1);
    repeat (LONG_ROW_WORDS) feed(pick_data(), 1'b0);

    // wind down
    in_valid <= 1'b0;
    for (int i = 0; i < END_WAIT && sb.pending() != 0; i++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.flush_leftovers();
    if (sb.fails == 0) begin
      $display("** png_scanline_unfilter_core: PASSED **");
    end else begin
      $display("** png_scanline_unfilter_core: FAILED **");
    end
    $finish;
  end

endmodule
